FILE: design/complex_dc_blocker_core_macros.svh
// assertion macros shared by the dc blocker rtl
`ifndef COMPLEX_DC_BLOCKER_CORE_MACROS_SVH
`define COMPLEX_DC_BLOCKER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// clocked check, switched off while reset is high
`define CDB_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked check that also holds during reset
`define CDB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CDB_ASSERT(lbl, clk, rst, prop, msg)
`define CDB_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: design/cdb_pkg.sv
// types and constants shared by the dc blocker modules
`default_nettype none
package cdb_pkg;

  localparam int SAMPLE_W = 16;
  localparam int RES_W    = 17;

  // one complex sample
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] i;
    logic signed [SAMPLE_W-1:0] q;
  } sample_t;

  // side data that travels with an item along the cells
  typedef struct packed {
    logic signed [RES_W-1:0]    a_i;
    logic signed [RES_W-1:0]    a_q;
    logic signed [SAMPLE_W-1:0] d_i;
    logic signed [SAMPLE_W-1:0] d_q;
  } aux_t;

endpackage
`default_nettype wire

FILE: design/cdb_delay_line.sv
// shift register delay line with enable, cleared by reset
`default_nettype none
module cdb_delay_line #(
  parameter int W = 32,
  parameter int N = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] tail
);

  logic [W-1:0] taps [N];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < N; k++) begin
        taps[k] <= '0;
      end
    end else if (en) begin
      taps[0] <= din;
      for (int k = 1; k < N; k++) begin
        taps[k] <= taps[k-1];
      end
    end
  end

  assign tail = taps[N-1];

endmodule
`default_nettype wire

FILE: design/cdb_avg_cell.sv
// one moving average cell: running sum, sample history, side data register
`default_nettype none
`include "complex_dc_blocker_core_macros.svh"
module cdb_avg_cell #(
  parameter int DEPTH = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_vld,
  output logic            in_rdy,
  input  cdb_pkg::sample_t in_smp,
  input  cdb_pkg::aux_t    in_aux,
  output logic            out_vld,
  input  logic            out_rdy,
  output cdb_pkg::sample_t out_avg,
  output cdb_pkg::aux_t    out_aux,
  output cdb_pkg::sample_t tail
);

  localparam int LOG   = $clog2(DEPTH);
  localparam int SUM_W = cdb_pkg::SAMPLE_W + LOG;

  logic                    vld;
  logic                    take;
  logic signed [SUM_W-1:0] sum_i, sum_q, sum_i_next, sum_q_next;
  logic [$bits(cdb_pkg::sample_t)-1:0] old_bits;
  cdb_pkg::sample_t        old;
  cdb_pkg::aux_t           aux;

  assign in_rdy = !vld || out_rdy;
  assign take   = in_vld && in_rdy;

  // history: tail is the sample from DEPTH items back
  cdb_delay_line #(
    .W($bits(cdb_pkg::sample_t)),
    .N(DEPTH)
  ) u_hist (
    .clk (clk),
    .rst (rst),
    .en  (take),
    .din (in_smp),
    .tail(old_bits)
  );
  assign old = cdb_pkg::sample_t'(old_bits);

  assign sum_i_next = sum_i + SUM_W'(in_smp.i) - SUM_W'(old.i);
  assign sum_q_next = sum_q + SUM_W'(in_smp.q) - SUM_W'(old.q);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= 1'b0;
      sum_i <= '0;
      sum_q <= '0;
    end else begin
      if (in_rdy) begin
        vld <= in_vld;
      end
      if (take) begin
        sum_i <= sum_i_next;
        sum_q <= sum_q_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      aux <= in_aux;
    end
  end

  // floor division by DEPTH is the upper part of the sum
  assign out_avg.i = sum_i[SUM_W-1:LOG];
  assign out_avg.q = sum_q[SUM_W-1:LOG];
  assign out_vld   = vld;
  assign out_aux   = aux;
  assign tail      = old;

  `CDB_ASSERT(a_take_fills, clk, rst, take |=> vld, "cell empty after transfer in")
  `CDB_ASSERT(a_hold_sum, clk, rst, !in_rdy |=> $stable(sum_i) && $stable(sum_q),
              "running sum moved while stalled")
  `CDB_ASSERT(a_stall_chain, clk, rst, vld && !out_rdy |-> !in_rdy,
              "full cell accepted while downstream stalled")

endmodule
`default_nettype wire

FILE: design/complex_dc_blocker_core.sv
// top level of the complex dc blocker: four averaging cells, delay, output register
`default_nettype none
`include "complex_dc_blocker_core_macros.svh"
// Complex DC blocker. Takes one 16-bit I/Q sample per transfer and returns one
// 17-bit DC-removed sample per transfer, in order. Four moving-average cells of
// DEPTH samples (DEPTH a power of two) sit in a row, each holding its running sum
// and sample history and passing its average to the next cell. Short mode
// (long_mode = 0) gives the input delayed by DEPTH-1 samples minus the second
// average; long mode gives the input delayed by 2*DEPTH-2 samples minus the
// fourth average. All four cells run in both modes, so a mode change takes effect
// on the next sample with the history already built up; write long_mode only
// while the block is idle. Throughput is one sample per clock while out_ready
// is not held low. An input transfer loads the first cell, and the item then
// moves through the other three cells and the output register to out_valid.
// Each cell's ready looks only at its own occupancy and the next stage, so
// bubbles close up and input keeps flowing while a result waits, until the
// cells fill. Storage is shift registers: DEPTH samples per cell plus DEPTH-1
// for the long mode delay, all cleared by reset.
module complex_dc_blocker_core #(
  parameter int DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_i,
  input  logic signed [15:0] in_q,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [16:0] out_i,
  output logic signed [16:0] out_q
);

  localparam int NCELL = 4;

  logic long_mode;

  // handshake chain: index k feeds cell k, index NCELL feeds the output register
  logic             c_vld [NCELL+1];
  logic             c_rdy [NCELL+1];
  cdb_pkg::sample_t c_smp [NCELL+1];
  cdb_pkg::aux_t    c_aux_in  [NCELL];
  cdb_pkg::aux_t    c_aux_out [NCELL];
  cdb_pkg::sample_t c_tail    [NCELL];

  logic [$bits(cdb_pkg::sample_t)-1:0] ext_bits;
  cdb_pkg::sample_t                    ext_tail;
  logic                                ext_en;
  logic signed [cdb_pkg::RES_W-1:0]    long_i, long_q;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      long_mode <= 1'b0;
    end else if (cfg_we) begin
      long_mode <= cfg_wdata;
    end
  end

  assign c_vld[0]   = in_valid;
  assign in_ready   = c_rdy[0];
  assign c_smp[0].i = in_i;
  assign c_smp[0].q = in_q;

  genvar k;
  generate
    for (k = 0; k < NCELL; k++) begin : g_cell
      cdb_avg_cell #(
        .DEPTH(DEPTH)
      ) u_cell (
        .clk    (clk),
        .rst    (rst),
        .in_vld (c_vld[k]),
        .in_rdy (c_rdy[k]),
        .in_smp (c_smp[k]),
        .in_aux (c_aux_in[k]),
        .out_vld(c_vld[k+1]),
        .out_rdy(c_rdy[k+1]),
        .out_avg(c_smp[k+1]),
        .out_aux(c_aux_out[k]),
        .tail   (c_tail[k])
      );
    end
  endgenerate

  // once the first cell has taken a sample, its history tail is the input from
  // DEPTH-1 samples earlier; that value enters the long mode delay when the item
  // moves on to the second cell
  assign ext_en = c_vld[1] && c_rdy[1];

  cdb_delay_line #(
    .W($bits(cdb_pkg::sample_t)),
    .N(DEPTH - 1)
  ) u_ext (
    .clk (clk),
    .rst (rst),
    .en  (ext_en),
    .din (c_tail[0]),
    .tail(ext_bits)
  );
  assign ext_tail = cdb_pkg::sample_t'(ext_bits);

  // side data: first cell carries nothing
  assign c_aux_in[0] = '0;

  // into the second cell: short mode delayed input and long mode delayed input
  assign c_aux_in[1].a_i = cdb_pkg::RES_W'(c_tail[0].i);
  assign c_aux_in[1].a_q = cdb_pkg::RES_W'(c_tail[0].q);
  assign c_aux_in[1].d_i = ext_tail.i;
  assign c_aux_in[1].d_q = ext_tail.q;

  // into the third cell: short mode result, delayed input minus second average
  assign c_aux_in[2].a_i = c_aux_out[1].a_i - cdb_pkg::RES_W'(c_smp[2].i);
  assign c_aux_in[2].a_q = c_aux_out[1].a_q - cdb_pkg::RES_W'(c_smp[2].q);
  assign c_aux_in[2].d_i = c_aux_out[1].d_i;
  assign c_aux_in[2].d_q = c_aux_out[1].d_q;

  assign c_aux_in[3] = c_aux_out[2];

  // long mode result, longer delayed input minus fourth average
  assign long_i = cdb_pkg::RES_W'(c_aux_out[3].d_i) - cdb_pkg::RES_W'(c_smp[4].i);
  assign long_q = cdb_pkg::RES_W'(c_aux_out[3].d_q) - cdb_pkg::RES_W'(c_smp[4].q);

  // output register
  assign c_rdy[NCELL] = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (c_rdy[NCELL]) begin
      out_valid <= c_vld[NCELL];
    end
  end

  always_ff @(posedge clk) begin
    if (c_vld[NCELL] && c_rdy[NCELL]) begin
      out_i <= long_mode ? long_i : c_aux_out[3].a_i;
      out_q <= long_mode ? long_q : c_aux_out[3].a_q;
    end
  end

  `CDB_ASSERT(a_empty_out_ready, clk, rst, !out_valid |-> in_ready,
              "input stalled with output register empty")
  `CDB_ASSERT(a_last_cell_to_out, clk, rst, c_vld[NCELL] && c_rdy[NCELL] |=> out_valid,
              "result lost between last cell and output register")
  `CDB_ASSERT(a_in_to_cell, clk, rst, in_valid && in_ready |=> c_vld[1],
              "sample lost entering first cell")

endmodule
`default_nettype wire
